### design/aorf_pkg.sv
package aorf_pkg;

  // Default frame store geometry
  localparam int MAX_WIDTH_DEF  = 256;
  localparam int MAX_HEIGHT_DEF = 256;

  // Canvas registers
  localparam int       CFG_DATA_W   = 9;
  localparam int       CFG_INDEX_W  = 1;
  localparam logic [CFG_DATA_W-1:0] CANVAS_RESET = 9'd256;
  localparam logic [CFG_INDEX_W-1:0] CFG_CANVAS_WIDTH  = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_CANVAS_HEIGHT = 1'd1;

  // Signed width used for rectangle clipping arithmetic
  localparam int GEO_W = 18;

  // Blend datapath widths
  localparam int DIVD_W    = 17;
  localparam int DIV_CNT_W = 5;
  localparam int NUM_CH    = 3;
  localparam logic [7:0] ALPHA_MAX = 8'd255;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_FILL  = 2'd1,
    OP_READ  = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SETUP,
    S_RD,
    S_BLS,
    S_BLW,
    S_PX,
    S_DONE
  } fsm_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_MUL1,
    B_MUL2,
    B_MUL3,
    B_DIV,
    B_DONE
  } blend_state_t;

  // Stored pixel layout: red in the low byte, alpha in the high byte
  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_t;

  typedef struct packed {
    logic [1:0]         operation;
    logic signed [15:0] left_x;
    logic signed [15:0] top_y;
    logic [11:0]        rect_width;
    logic [11:0]        rect_height;
    logic [7:0]         src_red;
    logic [7:0]         src_green;
    logic [7:0]         src_blue;
    logic [7:0]         src_alpha;
  } in_req_t;

  typedef struct packed {
    logic [7:0] pixel_red;
    logic [7:0] pixel_green;
    logic [7:0] pixel_blue;
    logic [7:0] pixel_alpha;
    logic       in_bounds;
  } out_res_t;

  // Exact x / 255 for x below 2^24 by reciprocal multiply
  function automatic logic [DIVD_W-1:0] div255(input logic [23:0] x);
    logic [55:0] prod;
    prod = {32'd0, x} * 56'h0000_0080_8080_81;
    return prod[55:39];
  endfunction

endpackage

### design/aorf_ram.sv
module aorf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Read first port: a read in a write cycle returns the old word, registered
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

### design/aorf_blend.sv
module aorf_blend (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  aorf_pkg::pixel_t old_px,
  input  aorf_pkg::pixel_t src_px,
  output logic             done,
  output aorf_pkg::pixel_t new_px
);

  localparam int NCH   = aorf_pkg::NUM_CH;
  localparam int DW    = aorf_pkg::DIVD_W;
  localparam int CNT_W = aorf_pkg::DIV_CNT_W;

  aorf_pkg::blend_state_t state_r, state_nxt;

  logic [7:0]       oc_r   [NCH];
  logic [7:0]       sc_r   [NCH];
  logic [7:0]       oa_r;
  logic [7:0]       sa_r;
  logic [15:0]      poc_r  [NCH];
  logic [15:0]      sca_r  [NCH];
  logic [15:0]      pa_r;
  logic [23:0]      num_r  [NCH];
  logic [7:0]       na_r;
  logic [DW-1:0]    quo_r  [NCH];
  logic [7:0]       rem_r  [NCH];
  logic [CNT_W-1:0] div_cnt_r;

  logic [7:0]    inv;
  logic [7:0]    old_ch [NCH];
  logic [7:0]    src_ch [NCH];
  logic [DW-1:0] pa_q;
  logic [DW-1:0] num_q  [NCH];
  logic [8:0]    trial  [NCH];
  logic [8:0]    diff   [NCH];
  logic          ge     [NCH];

  // Split pixels into channel lanes
  assign old_ch[0] = old_px.red;
  assign old_ch[1] = old_px.green;
  assign old_ch[2] = old_px.blue;
  assign src_ch[0] = src_px.red;
  assign src_ch[1] = src_px.green;
  assign src_ch[2] = src_px.blue;

  assign inv  = aorf_pkg::ALPHA_MAX - sa_r;
  assign pa_q = aorf_pkg::div255({8'd0, pa_r});

  // One restoring divide step per lane, shared divisor
  always_comb begin
    for (int k = 0; k < NCH; k++) begin
      num_q[k] = aorf_pkg::div255(num_r[k]);
      trial[k] = {rem_r[k], quo_r[k][DW-1]};
      diff[k]  = trial[k] - {1'b0, na_r};
      ge[k]    = trial[k] >= {1'b0, na_r};
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      aorf_pkg::B_IDLE: begin
        if (start) begin
          state_nxt = aorf_pkg::B_MUL1;
        end
      end
      aorf_pkg::B_MUL1: state_nxt = aorf_pkg::B_MUL2;
      aorf_pkg::B_MUL2: state_nxt = aorf_pkg::B_MUL3;
      aorf_pkg::B_MUL3: state_nxt = aorf_pkg::B_DIV;
      aorf_pkg::B_DIV: begin
        if (div_cnt_r == CNT_W'(DW - 1)) begin
          state_nxt = aorf_pkg::B_DONE;
        end
      end
      aorf_pkg::B_DONE: state_nxt = aorf_pkg::B_IDLE;
      default:          state_nxt = aorf_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= aorf_pkg::B_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath: capture, three product stages, then iterate the divide
  always_ff @(posedge clk) begin
    case (state_r)
      aorf_pkg::B_IDLE: begin
        if (start) begin
          for (int k = 0; k < NCH; k++) begin
            oc_r[k] <= old_ch[k];
            sc_r[k] <= src_ch[k];
          end
          oa_r <= old_px.alpha;
          sa_r <= src_px.alpha;
        end
      end
      aorf_pkg::B_MUL1: begin
        for (int k = 0; k < NCH; k++) begin
          poc_r[k] <= 16'(oc_r[k]) * 16'(oa_r);
          sca_r[k] <= 16'(sc_r[k]) * 16'(sa_r);
        end
        pa_r <= 16'(oa_r) * 16'(inv);
      end
      aorf_pkg::B_MUL2: begin
        for (int k = 0; k < NCH; k++) begin
          num_r[k] <= 24'(poc_r[k]) * 24'(inv);
        end
        na_r <= sa_r + pa_q[7:0];
      end
      aorf_pkg::B_MUL3: begin
        for (int k = 0; k < NCH; k++) begin
          quo_r[k] <= DW'(sca_r[k]) + num_q[k];
          rem_r[k] <= '0;
        end
        div_cnt_r <= '0;
      end
      aorf_pkg::B_DIV: begin
        for (int k = 0; k < NCH; k++) begin
          rem_r[k] <= ge[k] ? diff[k][7:0] : trial[k][7:0];
          quo_r[k] <= {quo_r[k][DW-2:0], ge[k]};
        end
        div_cnt_r <= div_cnt_r + CNT_W'(1);
      end
      default: begin
      end
    endcase
  end

  // Outputs: zero the pixel when the combined alpha is zero
  always_comb begin
    done   = (state_r == aorf_pkg::B_DONE);
    new_px = '0;
    if (na_r != 8'd0) begin
      new_px.alpha = na_r;
      new_px.red   = quo_r[0][7:0];
      new_px.green = quo_r[1][7:0];
      new_px.blue  = quo_r[2][7:0];
    end
  end

endmodule

### design/alpha_over_rect_fill.sv
// RGBA8 canvas with clear, blended rectangle fill and single pixel read.
// Requests enter on start/in_req and are taken when busy is low; every request
// gives exactly one result, shown on out_res for one cycle with out_valid high.
// Only a read returns pixel data; clear, fill and the spare code return zeros.
// Canvas size is written through cfg_we/cfg_index/cfg_data; keeping this to idle is left to the user.
// Steps per request, from acceptance to the strobe:
//   read  : setup, a store read when in bounds, then the result
//   fill  : setup, then per clipped pixel a read, a blend start,
//           three product stages and a 17 step divide in the blend unit, then
//           the write back; an empty fill and the spare code skip to the result
//   clear : the whole store swept, one store word written per cycle
// A new request is taken only once the previous one has given its result.
// The store port does one access per cycle, so a pixel is read only after the
// previous pixel has been written back and no forwarding is needed.
// After reset the block sweeps the whole store to zero, holding busy high
// throughout, and gives no result for that sweep.
// Results cannot be held off by the receiver; the next request may be accepted
// at the edge that ends its predecessor's result cycle.
module alpha_over_rect_fill #(
  parameter int MAX_WIDTH  = aorf_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = aorf_pkg::MAX_HEIGHT_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  aorf_pkg::in_req_t                   in_req,
  output logic                                busy,
  output logic                                out_valid,
  output aorf_pkg::out_res_t                  out_res,
  input  logic                                cfg_we,
  input  logic [aorf_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [aorf_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int YW    = $clog2(MAX_HEIGHT);
  localparam int CWW   = $clog2(MAX_WIDTH + 1);
  localparam int CHW   = $clog2(MAX_HEIGHT + 1);
  localparam int GW    = aorf_pkg::GEO_W;
  localparam int CDW   = aorf_pkg::CFG_DATA_W;
  localparam int PW    = $bits(aorf_pkg::pixel_t);

  aorf_pkg::fsm_state_t state_r, state_nxt;
  aorf_pkg::in_req_t    req_r;
  aorf_pkg::out_res_t   out_res_r, emit_res;
  aorf_pkg::pixel_t     rd_px, mixed_px, src_px;

  logic [CDW-1:0] cfg_w_r, cfg_h_r;
  logic [AW-1:0]  clr_addr_r;
  logic           clr_report_r;
  logic [XW-1:0]  x0_r, cur_x_r;
  logic [YW-1:0]  cur_y_r;
  logic [CWW-1:0] x1_r;
  logic [CHW-1:0] y1_r;
  logic           out_valid_r;

  logic signed [GW-1:0] x_s, y_s, w_s, h_s, cw_s, ch_s;
  logic signed [GW-1:0] xe_s, ye_s, x0_s, y0_s, x1_s, y1_s;
  logic                 fill_ok, rd_ok, clr_last, x_last, y_last;
  logic [AW-1:0]        pix_addr, ram_addr;
  logic [PW-1:0]        ram_wdata, ram_rdata;
  logic                 ram_we, blend_start, blend_done, emit_valid;
  aorf_pkg::op_t        op;

  assign op = aorf_pkg::op_t'(req_r.operation);

  // Clip the request against the effective canvas
  always_comb begin
    x_s  = {{(GW-16){req_r.left_x[15]}}, req_r.left_x};
    y_s  = {{(GW-16){req_r.top_y[15]}}, req_r.top_y};
    w_s  = {{(GW-12){1'b0}}, req_r.rect_width};
    h_s  = {{(GW-12){1'b0}}, req_r.rect_height};
    cw_s = ({{(GW-CDW){1'b0}}, cfg_w_r} > GW'(MAX_WIDTH)) ?
           GW'(MAX_WIDTH) : {{(GW-CDW){1'b0}}, cfg_w_r};
    ch_s = ({{(GW-CDW){1'b0}}, cfg_h_r} > GW'(MAX_HEIGHT)) ?
           GW'(MAX_HEIGHT) : {{(GW-CDW){1'b0}}, cfg_h_r};
    xe_s = x_s + w_s;
    ye_s = y_s + h_s;
    x0_s = x_s[GW-1] ? '0 : x_s;
    y0_s = y_s[GW-1] ? '0 : y_s;
    x1_s = (xe_s > cw_s) ? cw_s : xe_s;
    y1_s = (ye_s > ch_s) ? ch_s : ye_s;
    fill_ok = (x0_s < x1_s) && (y0_s < y1_s);
    rd_ok   = !x_s[GW-1] && !y_s[GW-1] && (x_s < cw_s) && (y_s < ch_s);
  end

  // Walk position and sweep end
  assign pix_addr = AW'(cur_y_r) * AW'(MAX_WIDTH) + AW'(cur_x_r);
  assign clr_last = (clr_addr_r == AW'(DEPTH - 1));
  assign x_last   = ((CWW+1)'(cur_x_r) + (CWW+1)'(1)) >= (CWW+1)'(x1_r);
  assign y_last   = ((CHW+1)'(cur_y_r) + (CHW+1)'(1)) >= (CHW+1)'(y1_r);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      aorf_pkg::S_CLEAR: begin
        if (clr_last) begin
          state_nxt = aorf_pkg::S_IDLE;
        end
      end
      aorf_pkg::S_IDLE: begin
        if (start) begin
          state_nxt = aorf_pkg::S_SETUP;
        end
      end
      aorf_pkg::S_SETUP: begin
        case (op)
          aorf_pkg::OP_CLEAR: state_nxt = aorf_pkg::S_CLEAR;
          aorf_pkg::OP_FILL:  state_nxt = fill_ok ? aorf_pkg::S_RD : aorf_pkg::S_DONE;
          aorf_pkg::OP_READ:  state_nxt = rd_ok ? aorf_pkg::S_RD : aorf_pkg::S_DONE;
          default:            state_nxt = aorf_pkg::S_DONE;
        endcase
      end
      aorf_pkg::S_RD: begin
        state_nxt = (op == aorf_pkg::OP_FILL) ? aorf_pkg::S_BLS : aorf_pkg::S_PX;
      end
      aorf_pkg::S_BLS: state_nxt = aorf_pkg::S_BLW;
      aorf_pkg::S_BLW: begin
        if (blend_done) begin
          state_nxt = (x_last && y_last) ? aorf_pkg::S_DONE : aorf_pkg::S_RD;
        end
      end
      aorf_pkg::S_PX:   state_nxt = aorf_pkg::S_IDLE;
      aorf_pkg::S_DONE: state_nxt = aorf_pkg::S_IDLE;
      default:          state_nxt = aorf_pkg::S_IDLE;
    endcase
  end

  // Outputs: store port, blend start, result
  always_comb begin
    busy        = (state_r != aorf_pkg::S_IDLE);
    ram_we      = 1'b0;
    ram_addr    = pix_addr;
    ram_wdata   = mixed_px;
    blend_start = 1'b0;
    emit_valid  = 1'b0;
    emit_res    = '0;
    case (state_r)
      aorf_pkg::S_CLEAR: begin
        ram_we     = 1'b1;
        ram_addr   = clr_addr_r;
        ram_wdata  = '0;
        emit_valid = clr_last && clr_report_r;
      end
      aorf_pkg::S_BLS: blend_start = 1'b1;
      aorf_pkg::S_BLW: ram_we = blend_done;
      aorf_pkg::S_PX: begin
        emit_valid           = 1'b1;
        emit_res.pixel_red   = rd_px.red;
        emit_res.pixel_green = rd_px.green;
        emit_res.pixel_blue  = rd_px.blue;
        emit_res.pixel_alpha = rd_px.alpha;
        emit_res.in_bounds   = 1'b1;
      end
      aorf_pkg::S_DONE: emit_valid = 1'b1;
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= aorf_pkg::S_CLEAR;
      clr_addr_r   <= '0;
      clr_report_r <= 1'b0;
      out_valid_r  <= 1'b0;
      cfg_w_r      <= aorf_pkg::CANVAS_RESET;
      cfg_h_r      <= aorf_pkg::CANVAS_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= emit_valid;
      if (state_r == aorf_pkg::S_CLEAR) begin
        clr_addr_r <= clr_addr_r + AW'(1);
      end
      if (state_r == aorf_pkg::S_SETUP) begin
        clr_addr_r   <= '0;
        clr_report_r <= 1'b1;
      end
      if (cfg_we) begin
        case (cfg_index)
          aorf_pkg::CFG_CANVAS_WIDTH:  cfg_w_r <= cfg_data;
          aorf_pkg::CFG_CANVAS_HEIGHT: cfg_h_r <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  // Request, walk position and result payload
  always_ff @(posedge clk) begin
    out_res_r <= emit_res;
    if (state_r == aorf_pkg::S_IDLE && start) begin
      req_r <= in_req;
    end
    if (state_r == aorf_pkg::S_SETUP) begin
      cur_x_r <= x0_s[XW-1:0];
      cur_y_r <= y0_s[YW-1:0];
      x0_r    <= x0_s[XW-1:0];
      x1_r    <= x1_s[CWW-1:0];
      y1_r    <= y1_s[CHW-1:0];
    end
    // Advance along the row, then wrap to the next row
    if (state_r == aorf_pkg::S_BLW && blend_done) begin
      if (!x_last) begin
        cur_x_r <= cur_x_r + XW'(1);
      end else begin
        cur_x_r <= x0_r;
        cur_y_r <= cur_y_r + YW'(1);
      end
    end
  end

  assign rd_px         = aorf_pkg::pixel_t'(ram_rdata);
  assign src_px.red    = req_r.src_red;
  assign src_px.green  = req_r.src_green;
  assign src_px.blue   = req_r.src_blue;
  assign src_px.alpha  = req_r.src_alpha;
  assign out_valid     = out_valid_r;
  assign out_res       = out_res_r;

  aorf_ram #(
    .WIDTH (PW),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  aorf_blend u_blend (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (blend_start),
    .old_px (rd_px),
    .src_px (src_px),
    .done   (blend_done),
    .new_px (mixed_px)
  );

  // A result is shown only once the block is free again
  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while busy");

  // Results without a pixel carry zero color
  a_out_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_res.in_bounds |->
      out_res.pixel_red == 8'd0 && out_res.pixel_green == 8'd0 &&
      out_res.pixel_blue == 8'd0 && out_res.pixel_alpha == 8'd0)
    else $error("non-read result carries pixel data");

  // The blend unit finishes only while the walker waits for it
  a_blend_sync: assert property (@(posedge clk) disable iff (!rst_n)
    blend_done |-> state_r == aorf_pkg::S_BLW)
    else $error("blend finished outside write-back wait");

  // An accepted request never yields a result in the next cycle
  a_accept: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy && !out_valid)
    else $error("accepted request not held");

endmodule
